FILE: hdl/pmst_pkg.sv
package pmst_pkg;

  // item kind carried in s_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // node store entry layout, valid bit on top
  localparam int unsigned ENTRY_VALID_POS_OFS = 0;

endpackage

FILE: hdl/parabola_min_segment_tree_top.sv
// after reset a clearing pass writes all 2**(clog2(NUM_POINTS)+1) nodes empty,
// 8192 at the defaults, with s_tready low
// query: visits clog2(NUM_POINTS)+1 nodes and evaluates the stored parabola of each filled one
// insert: writes each empty node reached and compares the new item against each filled one;
// the vertex divider is serial and the multiply chain is shared, so there is
// one item in flight at a time; a pending result waits in the output register
module parabola_min_segment_tree_top
  import pmst_pkg::*;
#(
  parameter int NUM_POINTS = 4096,
  parameter int COEF_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // coef_a, coef_b, coef_c, point_x, zero pad
  input  logic [((3*COEF_BITS+$clog2(NUM_POINTS)+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // min_value, zero pad
  output logic [((COEF_BITS+2*$clog2(NUM_POINTS)+1+7)/8)*8-1:0] m_tdata,
  // is_empty
  output logic [0:0] m_tuser
);

  localparam int XW    = $clog2(NUM_POINTS);
  localparam int PW    = XW + 1;
  localparam int NODES = 2 ** PW;
  localparam int CB    = COEF_BITS;
  localparam int DW    = CB + 1;
  localparam int EW    = DW + 2*XW + 2;
  localparam int VW    = CB + 2*XW + 1;
  localparam int OBW   = ((VW + 7) / 8) * 8;
  localparam int SD    = XW + 1;
  localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int SCW   = $clog2(SD + 1);
  localparam int CW    = DW + 1 + XW;
  localparam int DCW   = (XW > 1) ? $clog2(XW) : 1;
  localparam int MW    = 1 + 3*CB;
  localparam logic [PW-1:0] NPT = PW'(NUM_POINTS);
  localparam logic signed [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic [PW-1:0]        node;
    logic [PW-1:0]        lo;
    logic [PW-1:0]        hi;
    logic signed [CB-1:0] a;
    logic signed [CB-1:0] b;
    logic signed [CB-1:0] c;
  } job_t;

  typedef enum logic [4:0] {
    CLEAR, IDLE, POP, RD, LD, PREP, DIV, EV0, E1, E2, E3,
    DECIDE, PUSHL, WR, Q_RD, Q_LD, Q_NX, Q_OUT
  } state_t;

  state_t state;

  // node store
  logic [MW-1:0] mem [NODES];
  logic [MW-1:0] mem_q;
  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  logic [PW-1:0] clr;
  logic [PW-1:0] nd, lo, hi;
  logic signed [CB-1:0] ja, jb, jc, ga, gb, gc, wa, wb, wc, la, lb, lc;
  logic signed [DW-1:0] da, db, dc, ea, eb, ec;
  job_t stk [SD];
  logic [SCW-1:0] cnt;
  logic pl;

  logic [CW-1:0]  rem, den;
  logic [XW-1:0]  q;
  logic [DCW-1:0] dcnt;
  logic [PW-1:0]  qv, q1, px;
  logic [2:0]     k;
  logic           qmode;

  logic [2*XW-1:0]             xsq;
  logic signed [DW+XW:0]       bx;
  logic signed [DW+2*XW:0]     ax;
  logic signed [EW-1:0]        val;
  logic signed [EW-1:0]        f_mn, f_mx, l_mn, l_mx, r_mn, r_mx, dmid, best;
  logic                        found;
  logic [PW-1:0]               qx;

  logic [PW:0]     sum_lh;
  logic [PW-1:0]   mid, hm1, pk, sel_p;
  logic [SCW-1:0]  cnt_m1;
  logic [CW-1:0]   sh;
  logic            ge;
  logic [XW-1:0]   qn;
  logic signed [DW:0] da_x, db_x, numv;
  logic [DW:0]     denv;
  logic [PW-1:0]   in_px;
  logic newwin;
  logic [VW-1:0] outv;
  logic outempty;
  logic out_load;

  assign sum_lh = {1'b0, lo} + {1'b0, hi};
  assign mid    = sum_lh[PW:1];
  assign hm1    = hi - PW'(1);
  assign cnt_m1 = cnt - SCW'(1);
  assign sh     = den << dcnt;
  assign ge     = rem >= sh;
  assign qn     = q | (ge ? (XW'(1) << dcnt) : '0);
  assign da_x   = (DW+1)'(da);
  assign db_x   = (DW+1)'(db);
  assign numv   = da[DW-1] ? db_x : -db_x;
  assign denv   = da[DW-1] ? (DW+1)'(-da_x) << 1 : (DW+1)'(da_x) << 1;
  assign val    = EW'(ax) + EW'(bx) + EW'(ec);
  assign in_px  = {1'b0, s_tdata[3*CB +: XW]};
  assign newwin = dmid[EW-1];
  assign out_load = (state == Q_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    case (k)
      3'd0:    pk = lo;
      3'd1:    pk = hm1;
      3'd2:    pk = mid - PW'(1);
      3'd3:    pk = mid;
      3'd4:    pk = qv;
      default: pk = q1;
    endcase
    if (pk < lo) sel_p = lo;
    else if (pk > hm1) sel_p = hm1;
    else sel_p = pk;
  end

  assign s_tready = (state == IDLE);
  assign m_tdata  = OBW'(outv);
  assign m_tuser  = outempty;

  assign mem_we = (state == CLEAR) || (state == WR);
  assign mem_wa = (state == CLEAR) ? clr : nd;
  assign mem_wd = (state == CLEAR) ? '0 : {1'b1, wa, wb, wc};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[nd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        CLEAR: begin
          clr <= clr + PW'(1);
          if (clr == PW'(NODES - 1)) state <= IDLE;
        end
        IDLE: begin
          if (s_tvalid) begin
            nd <= PW'(1);
            lo <= '0;
            hi <= NPT;
            if (s_tuser[0] == ACT_INSERT) begin
              ja    <= s_tdata[0 +: CB];
              jb    <= s_tdata[CB +: CB];
              jc    <= s_tdata[2*CB +: CB];
              cnt   <= '0;
              state <= RD;
            end else begin
              qx    <= (in_px >= NPT) ? NPT - PW'(1) : in_px;
              found <= 1'b0;
              best  <= '0;
              state <= Q_RD;
            end
          end
        end
        POP: begin
          if (cnt == '0) begin
            state <= IDLE;
          end else begin
            nd    <= stk[cnt_m1[SIW-1:0]].node;
            lo    <= stk[cnt_m1[SIW-1:0]].lo;
            hi    <= stk[cnt_m1[SIW-1:0]].hi;
            ja    <= stk[cnt_m1[SIW-1:0]].a;
            jb    <= stk[cnt_m1[SIW-1:0]].b;
            jc    <= stk[cnt_m1[SIW-1:0]].c;
            cnt   <= cnt_m1;
            state <= RD;
          end
        end
        RD: state <= LD;
        LD: begin
          if (!mem_q[MW-1]) begin
            wa    <= ja;
            wb    <= jb;
            wc    <= jc;
            state <= WR;
          end else begin
            ga    <= mem_q[2*CB +: CB];
            gb    <= mem_q[CB +: CB];
            gc    <= mem_q[0 +: CB];
            da    <= DW'(ja) - DW'($signed(mem_q[2*CB +: CB]));
            db    <= DW'(jb) - DW'($signed(mem_q[CB +: CB]));
            dc    <= DW'(jc) - DW'($signed(mem_q[0 +: CB]));
            state <= PREP;
          end
        end
        PREP: begin
          ea    <= da;
          eb    <= db;
          ec    <= dc;
          qmode <= 1'b0;
          k     <= '0;
          f_mn  <= VMAX;
          l_mn  <= VMAX;
          r_mn  <= VMAX;
          f_mx  <= VMIN;
          l_mx  <= VMIN;
          r_mx  <= VMIN;
          q     <= '0;
          // vertex below zero or no vertex: lo stands in for it
          if (da == '0 || numv[DW]) begin
            qv    <= '0;
            q1    <= '0;
            state <= EV0;
          end else if (CW'(numv) >= (CW'(denv) << XW)) begin
            qv    <= '1;
            q1    <= '1;
            state <= EV0;
          end else begin
            rem   <= CW'(numv);
            den   <= CW'(denv);
            dcnt  <= DCW'(XW - 1);
            state <= DIV;
          end
        end
        DIV: begin
          // one quotient bit per cycle, floor of the vertex position
          if (ge) rem <= rem - sh;
          q    <= qn;
          dcnt <= dcnt - DCW'(1);
          if (dcnt == '0) begin
            qv    <= {1'b0, qn};
            q1    <= {1'b0, qn} + PW'(1);
            state <= EV0;
          end
        end
        EV0: begin
          px    <= sel_p;
          state <= E1;
        end
        E1: begin
          xsq   <= px[XW-1:0] * px[XW-1:0];
          bx    <= eb * $signed({1'b0, px[XW-1:0]});
          state <= E2;
        end
        E2: begin
          ax    <= ea * $signed({1'b0, xsq});
          state <= E3;
        end
        E3: begin
          if (qmode) begin
            if (!found || val < best) best <= val;
            found <= 1'b1;
            state <= Q_NX;
          end else begin
            if (val < f_mn) f_mn <= val;
            if (val > f_mx) f_mx <= val;
            if (px < mid) begin
              if (val < l_mn) l_mn <= val;
              if (val > l_mx) l_mx <= val;
            end else begin
              if (val < r_mn) r_mn <= val;
              if (val > r_mx) r_mx <= val;
            end
            if (k == 3'd3) dmid <= val;
            k     <= k + 3'd1;
            state <= (k == 3'd5) ? DECIDE : EV0;
          end
        end
        DECIDE: begin
          if (!f_mn[EW-1]) begin
            state <= POP;
          end else if (f_mx[EW-1] || f_mx == '0) begin
            wa    <= ja;
            wb    <= jb;
            wc    <= jc;
            state <= WR;
          end else begin
            wa <= newwin ? ja : ga;
            wb <= newwin ? jb : gb;
            wc <= newwin ? jc : gc;
            la <= newwin ? ga : ja;
            lb <= newwin ? gb : jb;
            lc <= newwin ? gc : jc;
            pl <= newwin ? (!l_mx[EW-1] && l_mx != '0) : l_mn[EW-1];
            // loser still wins somewhere on the right half
            if ((newwin ? (!r_mx[EW-1] && r_mx != '0) : r_mn[EW-1]) &&
                cnt < SCW'(SD)) begin
              stk[cnt[SIW-1:0]] <= '{node: {nd[PW-2:0], 1'b1}, lo: mid, hi: hi,
                                     a: newwin ? ga : ja, b: newwin ? gb : jb,
                                     c: newwin ? gc : jc};
              cnt <= cnt + SCW'(1);
            end
            state <= PUSHL;
          end
        end
        PUSHL: begin
          if (pl && cnt < SCW'(SD)) begin
            stk[cnt[SIW-1:0]] <= '{node: {nd[PW-2:0], 1'b0}, lo: lo, hi: mid,
                                   a: la, b: lb, c: lc};
            cnt <= cnt + SCW'(1);
          end
          state <= WR;
        end
        WR: state <= POP;
        Q_RD: state <= Q_LD;
        Q_LD: begin
          if (mem_q[MW-1]) begin
            ea    <= DW'($signed(mem_q[2*CB +: CB]));
            eb    <= DW'($signed(mem_q[CB +: CB]));
            ec    <= DW'($signed(mem_q[0 +: CB]));
            px    <= qx;
            qmode <= 1'b1;
            state <= E1;
          end else begin
            state <= Q_NX;
          end
        end
        Q_NX: begin
          if (hi - lo <= PW'(1)) begin
            state <= Q_OUT;
          end else begin
            if (qx < mid) begin
              nd <= {nd[PW-2:0], 1'b0};
              hi <= mid;
            end else begin
              nd <= {nd[PW-2:0], 1'b1};
              lo <= mid;
            end
            state <= Q_RD;
          end
        end
        Q_OUT: begin
          if (out_load) begin
            outv     <= found ? best[VW-1:0] : '0;
            outempty <= !found;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= SCW'(SD))
    else $error("pending stack count beyond depth");

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> cnt == '0)
    else $error("new word taken while insert jobs pending");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == DIV |-> rem < (den << (dcnt + DCW'(1))))
    else $error("vertex divider remainder out of range");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == Q_OUT)
    else $error("result word not from a finished query");

  a_write_node: assert property (@(posedge clk) disable iff (rst)
    state == WR |-> nd != '0)
    else $error("write to unused node zero");

endmodule
